FILE: hw/rtl/goq_pkg.sv
// Shared types and constants for the group order queue.
package goq_pkg;

    localparam int DEF_ROSTER_DEPTH = 256;
    localparam int DEF_QUEUE_DEPTH  = 256;

    localparam int KEY_W    = 32;
    localparam int GROUP_W  = 8;
    localparam int STATUS_W = 3;
    localparam int OP_W     = 2;

    localparam logic [GROUP_W-1:0] GROUP_COUNT_RESET = 8'd255;

    typedef enum logic [OP_W-1:0] {
        OP_REGISTER = 2'd0,
        OP_ENQUEUE  = 2'd1,
        OP_DEQUEUE  = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DEQUEUED   = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_ENQUEUED   = 3'd2,
        ST_UNKNOWN    = 3'd3,
        ST_REGISTERED = 3'd4,
        ST_REJECTED   = 3'd5,
        ST_FULL       = 3'd6
    } status_t;

    // what a queue cell loads at the next edge
    typedef enum logic [1:0] {
        MODE_HOLD     = 2'd0,
        MODE_TAKE_LO  = 2'd1,
        MODE_TAKE_HI  = 2'd2,
        MODE_TAKE_NEW = 2'd3
    } cell_mode_t;

endpackage

FILE: hw/rtl/goq_roster_cell.sv
// One roster cell: stored key, group and shadow flag, with a registered lookup hit.
module goq_roster_cell
(
    input  logic                        clk,
    input  logic                        shift,
    input  logic                        capture,
    input  logic                        live,
    input  logic [goq_pkg::KEY_W-1:0]   cmp_key,
    input  logic [goq_pkg::KEY_W-1:0]   prev_key,
    input  logic [goq_pkg::GROUP_W-1:0] prev_grp,
    input  logic                        prev_dup,
    input  logic                        prev_match,
    output logic [goq_pkg::KEY_W-1:0]   key,
    output logic [goq_pkg::GROUP_W-1:0] grp,
    output logic                        dup,
    output logic                        match,
    output logic                        hit
);

    logic [goq_pkg::KEY_W-1:0]   key_reg;
    logic [goq_pkg::GROUP_W-1:0] grp_reg;
    logic                        dup_reg;
    logic                        hit_reg;

    // a shadowed entry is a later copy of a key already present
    assign match = live && !dup_reg && (key_reg == cmp_key);

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            key_reg <= prev_key;
            grp_reg <= prev_grp;
            dup_reg <= prev_dup;
        end
        if (capture)
        begin
            hit_reg <= shift ? prev_match : match;
        end
    end

    assign key = key_reg;
    assign grp = grp_reg;
    assign dup = dup_reg;
    assign hit = hit_reg;

endmodule

FILE: hw/rtl/goq_queue_cell.sv
// One queue cell: key and group of one queued entry, loaded from a neighbor or a new word.
module goq_queue_cell
(
    input  logic                        clk,
    input  goq_pkg::cell_mode_t         mode,
    input  logic                        live,
    input  logic [goq_pkg::GROUP_W-1:0] cmp_grp,
    input  logic [goq_pkg::KEY_W-1:0]   lo_key,
    input  logic [goq_pkg::GROUP_W-1:0] lo_grp,
    input  logic [goq_pkg::KEY_W-1:0]   hi_key,
    input  logic [goq_pkg::GROUP_W-1:0] hi_grp,
    input  logic [goq_pkg::KEY_W-1:0]   new_key,
    input  logic [goq_pkg::GROUP_W-1:0] new_grp,
    output logic [goq_pkg::KEY_W-1:0]   key,
    output logic [goq_pkg::GROUP_W-1:0] grp,
    output logic                        match
);

    logic [goq_pkg::KEY_W-1:0]   key_reg;
    logic [goq_pkg::GROUP_W-1:0] grp_reg;

    assign match = live && (grp_reg == cmp_grp);

    always_ff @(posedge clk)
    begin
        unique case (mode)
            goq_pkg::MODE_HOLD:
            begin
                key_reg <= key_reg;
                grp_reg <= grp_reg;
            end
            goq_pkg::MODE_TAKE_LO:
            begin
                key_reg <= lo_key;
                grp_reg <= lo_grp;
            end
            goq_pkg::MODE_TAKE_HI:
            begin
                key_reg <= hi_key;
                grp_reg <= hi_grp;
            end
            goq_pkg::MODE_TAKE_NEW:
            begin
                key_reg <= new_key;
                grp_reg <= new_grp;
            end
        endcase
    end

    assign key = key_reg;
    assign grp = grp_reg;

endmodule

FILE: hw/rtl/goq_roster.sv
// Roster chain: new entries shift in at cell 0, parallel key lookup with one-hot group select.
module goq_roster
#(
    parameter int ROSTER_DEPTH = goq_pkg::DEF_ROSTER_DEPTH
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        capture,
    input  logic [goq_pkg::KEY_W-1:0]   cmp_key,
    input  logic                        push,
    input  logic [goq_pkg::KEY_W-1:0]   new_key,
    input  logic [goq_pkg::GROUP_W-1:0] new_grp,
    input  logic                        new_dup,
    output logic                        hit_any,
    output logic [goq_pkg::GROUP_W-1:0] hit_grp,
    output logic                        full
);

    localparam int CNT_W = $clog2(ROSTER_DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic [goq_pkg::KEY_W-1:0]   cell_key  [0:ROSTER_DEPTH-1];
    logic [goq_pkg::GROUP_W-1:0] cell_grp  [0:ROSTER_DEPTH-1];
    logic [ROSTER_DEPTH-1:0]     cell_dup;
    logic [ROSTER_DEPTH-1:0]     cell_match;
    logic [ROSTER_DEPTH-1:0]     cell_hit;
    logic [ROSTER_DEPTH-1:0]     cell_live;

    logic [goq_pkg::KEY_W-1:0]   prev_key  [0:ROSTER_DEPTH-1];
    logic [goq_pkg::GROUP_W-1:0] prev_grp  [0:ROSTER_DEPTH-1];
    logic [ROSTER_DEPTH-1:0]     prev_dup;
    logic [ROSTER_DEPTH-1:0]     prev_match;

    logic new_match;

    assign new_match = !new_dup && (new_key == cmp_key);

    for (genvar i = 0; i < ROSTER_DEPTH; i++)
    begin : g_cell
        assign cell_live[i] = (count_reg > CNT_W'(i));

        if (i == 0)
        begin : g_head
            assign prev_key[i]   = new_key;
            assign prev_grp[i]   = new_grp;
            assign prev_dup[i]   = new_dup;
            assign prev_match[i] = new_match;
        end
        else
        begin : g_link
            assign prev_key[i]   = cell_key[i-1];
            assign prev_grp[i]   = cell_grp[i-1];
            assign prev_dup[i]   = cell_dup[i-1];
            assign prev_match[i] = cell_match[i-1];
        end

        goq_roster_cell u_cell
        (
            .clk        (clk),
            .shift      (push),
            .capture    (capture),
            .live       (cell_live[i]),
            .cmp_key    (cmp_key),
            .prev_key   (prev_key[i]),
            .prev_grp   (prev_grp[i]),
            .prev_dup   (prev_dup[i]),
            .prev_match (prev_match[i]),
            .key        (cell_key[i]),
            .grp        (cell_grp[i]),
            .dup        (cell_dup[i]),
            .match      (cell_match[i]),
            .hit        (cell_hit[i])
        );
    end

    // at most one unshadowed entry can hit
    always_comb
    begin
        hit_grp = '0;
        for (int i = 0; i < ROSTER_DEPTH; i++)
        begin
            hit_grp = hit_grp | ({goq_pkg::GROUP_W{cell_hit[i]}} & cell_grp[i]);
        end
    end

    assign hit_any    = |cell_hit;
    assign full       = (count_reg == CNT_W'(ROSTER_DEPTH));
    assign count_next = push ? (count_reg + CNT_W'(1)) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

FILE: hw/rtl/goq_queue.sv
// Queue chain: group compare per cell, first run end by prefix OR, shift insert and shift out.
module goq_queue
#(
    parameter int QUEUE_DEPTH = goq_pkg::DEF_QUEUE_DEPTH
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        enq,
    input  logic                        deq,
    input  logic [goq_pkg::KEY_W-1:0]   new_key,
    input  logic [goq_pkg::GROUP_W-1:0] new_grp,
    output logic [goq_pkg::KEY_W-1:0]   head_key,
    output logic [goq_pkg::GROUP_W-1:0] head_grp,
    output logic                        empty,
    output logic                        full
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int LVL   = $clog2(QUEUE_DEPTH);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic [goq_pkg::KEY_W-1:0]   cell_key [0:QUEUE_DEPTH-1];
    logic [goq_pkg::GROUP_W-1:0] cell_grp [0:QUEUE_DEPTH-1];
    logic [QUEUE_DEPTH-1:0]      cell_match;
    logic [QUEUE_DEPTH-1:0]      cell_live;
    goq_pkg::cell_mode_t         cell_mode [0:QUEUE_DEPTH-1];

    logic [goq_pkg::KEY_W-1:0]   lo_key [0:QUEUE_DEPTH-1];
    logic [goq_pkg::GROUP_W-1:0] lo_grp [0:QUEUE_DEPTH-1];
    logic [goq_pkg::KEY_W-1:0]   hi_key [0:QUEUE_DEPTH-1];
    logic [goq_pkg::GROUP_W-1:0] hi_grp [0:QUEUE_DEPTH-1];

    logic [QUEUE_DEPTH-1:0] run_end;
    logic [QUEUE_DEPTH-1:0] pfx [0:LVL];
    logic [QUEUE_DEPTH-1:0] after;
    logic                   any_end;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        assign cell_live[i] = (count_reg > CNT_W'(i));

        if (i == 0)
        begin : g_lo_head
            assign lo_key[i] = new_key;
            assign lo_grp[i] = new_grp;
        end
        else
        begin : g_lo_link
            assign lo_key[i] = cell_key[i-1];
            assign lo_grp[i] = cell_grp[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_hi_tail
            assign hi_key[i] = cell_key[i];
            assign hi_grp[i] = cell_grp[i];
        end
        else
        begin : g_hi_link
            assign hi_key[i] = cell_key[i+1];
            assign hi_grp[i] = cell_grp[i+1];
        end

        goq_queue_cell u_cell
        (
            .clk     (clk),
            .mode    (cell_mode[i]),
            .live    (cell_live[i]),
            .cmp_grp (new_grp),
            .lo_key  (lo_key[i]),
            .lo_grp  (lo_grp[i]),
            .hi_key  (hi_key[i]),
            .hi_grp  (hi_grp[i]),
            .new_key (new_key),
            .new_grp (new_grp),
            .key     (cell_key[i]),
            .grp     (cell_grp[i]),
            .match   (cell_match[i])
        );
    end

    // insertion point: first cell that ends a run of the group, else the tail
    always_comb
    begin
        run_end[0] = 1'b0;
        for (int i = 1; i < QUEUE_DEPTH; i++)
        begin
            run_end[i] = cell_match[i-1] && !cell_match[i];
        end

        pfx[0] = run_end;
        for (int k = 0; k < LVL; k++)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                if (i >= (1 << k))
                begin
                    pfx[k+1][i] = pfx[k][i] | pfx[k][i - (1 << k)];
                end
                else
                begin
                    pfx[k+1][i] = pfx[k][i];
                end
            end
        end

        any_end = pfx[LVL][QUEUE_DEPTH-1];
        after   = any_end ? pfx[LVL] : ~cell_live;

        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (deq)
            begin
                cell_mode[i] = goq_pkg::MODE_TAKE_HI;
            end
            else if (enq && after[i])
            begin
                if (i > 0 && after[i-1])
                begin
                    cell_mode[i] = goq_pkg::MODE_TAKE_LO;
                end
                else
                begin
                    cell_mode[i] = goq_pkg::MODE_TAKE_NEW;
                end
            end
            else
            begin
                cell_mode[i] = goq_pkg::MODE_HOLD;
            end
        end
    end

    assign head_key = cell_key[0];
    assign head_grp = cell_grp[0];
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));

    always_comb
    begin
        priority if (enq)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (deq)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

FILE: hw/rtl/group_order_queue.sv
// Top level of the group order queue: handshakes, sequencing, result register.
//
// Group order queue. Operation 0 registers a key with a group in 1..group_count
// (reset 255), operation 1 enqueues a registered key right behind the first run
// of its group or at the tail, operation 2 dequeues the head, and operation 3
// is dropped with no result. An operation runs through S_SEL and S_EXEC: a
// parallel key compare across the roster cells is registered at acceptance,
// the matching group is selected and registered in S_SEL, and S_EXEC does the
// group compare, run search and shift in the queue cells, or the roster shift
// for a registration, and loads the result register when no stalled result is
// waiting. The next word is accepted at the edge that loads the result, so a
// new word is taken only once the one before it is through. No clearing pass
// runs after reset. group_count is written through cfg_we and cfg_data and must
// only change while the block is idle.
module group_order_queue
#(
    parameter int ROSTER_DEPTH = goq_pkg::DEF_ROSTER_DEPTH,
    parameter int QUEUE_DEPTH  = goq_pkg::DEF_QUEUE_DEPTH
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_we,
    input  logic [goq_pkg::GROUP_W-1:0]  cfg_data,

    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic [goq_pkg::OP_W-1:0]     operation,
    input  logic [goq_pkg::KEY_W-1:0]    student_key,
    input  logic [goq_pkg::GROUP_W-1:0]  group_number,

    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [goq_pkg::STATUS_W-1:0] status,
    output logic [goq_pkg::KEY_W-1:0]    head_key,
    output logic [goq_pkg::GROUP_W-1:0]  head_group
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SEL  = 3'b010,
        S_EXEC = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [goq_pkg::GROUP_W-1:0] group_count_reg;

    goq_pkg::op_t                op_reg;
    logic [goq_pkg::KEY_W-1:0]   key_reg;
    logic [goq_pkg::GROUP_W-1:0] grp_reg;
    logic                        known_reg;
    logic [goq_pkg::GROUP_W-1:0] lgrp_reg;

    logic                        result_valid_reg;
    goq_pkg::status_t            status_reg;
    logic [goq_pkg::KEY_W-1:0]   head_key_reg;
    logic [goq_pkg::GROUP_W-1:0] head_group_reg;

    goq_pkg::status_t            status_next;
    logic [goq_pkg::KEY_W-1:0]   head_key_next;
    logic [goq_pkg::GROUP_W-1:0] head_group_next;

    logic accept;
    logic finish;
    logic in_none;
    logic grp_bad;
    logic roster_push;
    logic q_enq;
    logic q_deq;

    logic                        hit_any;
    logic [goq_pkg::GROUP_W-1:0] hit_grp;
    logic                        roster_full;
    logic [goq_pkg::KEY_W-1:0]   q_head_key;
    logic [goq_pkg::GROUP_W-1:0] q_head_grp;
    logic                        q_empty;
    logic                        q_full;

    assign finish     = (state_reg == S_EXEC) && (!result_valid_reg || !result_stall);
    assign item_stall = !((state_reg == S_IDLE) || finish);
    assign accept     = item_valid && !item_stall;
    assign in_none    = (goq_pkg::op_t'(operation) == goq_pkg::OP_NONE);
    assign grp_bad    = (grp_reg == '0) || (grp_reg > group_count_reg);

    goq_roster
    #(
        .ROSTER_DEPTH (ROSTER_DEPTH)
    )
    u_roster
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .capture (accept),
        .cmp_key (student_key),
        .push    (roster_push),
        .new_key (key_reg),
        .new_grp (grp_reg),
        .new_dup (known_reg),
        .hit_any (hit_any),
        .hit_grp (hit_grp),
        .full    (roster_full)
    );

    goq_queue
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .enq      (q_enq),
        .deq      (q_deq),
        .new_key  (key_reg),
        .new_grp  (lgrp_reg),
        .head_key (q_head_key),
        .head_grp (q_head_grp),
        .empty    (q_empty),
        .full     (q_full)
    );

    always_comb
    begin
        status_next     = goq_pkg::ST_EMPTY;
        head_key_next   = '0;
        head_group_next = '0;
        roster_push     = 1'b0;
        q_enq           = 1'b0;
        q_deq           = 1'b0;
        unique case (op_reg)
            goq_pkg::OP_REGISTER:
            begin
                if (grp_bad)
                begin
                    status_next = goq_pkg::ST_REJECTED;
                end
                else if (roster_full)
                begin
                    status_next = goq_pkg::ST_FULL;
                end
                else
                begin
                    status_next = goq_pkg::ST_REGISTERED;
                    roster_push = finish;
                end
            end
            goq_pkg::OP_ENQUEUE:
            begin
                if (!known_reg)
                begin
                    status_next = goq_pkg::ST_UNKNOWN;
                end
                else if (q_full)
                begin
                    status_next = goq_pkg::ST_FULL;
                end
                else
                begin
                    status_next = goq_pkg::ST_ENQUEUED;
                    q_enq       = finish;
                end
            end
            goq_pkg::OP_DEQUEUE:
            begin
                if (q_empty)
                begin
                    status_next = goq_pkg::ST_EMPTY;
                end
                else
                begin
                    status_next     = goq_pkg::ST_DEQUEUED;
                    head_key_next   = q_head_key;
                    head_group_next = q_head_grp;
                    q_deq           = finish;
                end
            end
            goq_pkg::OP_NONE:
            begin
                status_next = goq_pkg::ST_EMPTY;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = in_none ? S_IDLE : S_SEL;
                end
            end
            S_SEL:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (finish)
                begin
                    state_next = (accept && !in_none) ? S_SEL : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            group_count_reg  <= goq_pkg::GROUP_COUNT_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                group_count_reg <= cfg_data;
            end
            if (finish)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= goq_pkg::op_t'(operation);
            key_reg <= student_key;
            grp_reg <= group_number;
        end
        if (state_reg == S_SEL)
        begin
            known_reg <= hit_any;
            lgrp_reg  <= hit_grp;
        end
        if (finish)
        begin
            status_reg     <= status_next;
            head_key_reg   <= head_key_next;
            head_group_reg <= head_group_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign head_key     = head_key_reg;
    assign head_group   = head_group_reg;

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for group_order_queue: directed table, random words, fills.
module tb_top;
    import goq_pkg::*;

    localparam int ROSTER_SLOTS = DEF_ROSTER_DEPTH;
    localparam int LINE_SLOTS   = DEF_QUEUE_DEPTH;
    localparam int DIR_COUNT    = 23;

    typedef struct packed {
        status_t              st;
        logic [KEY_W-1:0]     key;
        logic [GROUP_W-1:0]   grp;
    } reply_t;

    typedef struct packed {
        op_t                  op;
        logic [KEY_W-1:0]     key;
        logic [GROUP_W-1:0]   grp;
        logic                 typed;
        reply_t               want;
    } stim_row_t;

    localparam reply_t NO_REPLY = '{ST_DEQUEUED, 32'h0, 8'h0};

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [GROUP_W-1:0]     cfg_data;
    logic                   item_valid;
    logic                   item_stall;
    logic [OP_W-1:0]        operation;
    logic [KEY_W-1:0]       student_key;
    logic [GROUP_W-1:0]     group_number;
    logic                   result_valid;
    logic                   result_stall;
    logic [STATUS_W-1:0]    status;
    logic [KEY_W-1:0]       head_key;
    logic [GROUP_W-1:0]     head_group;

    // shadow copy of the roster, the line and the group limit
    logic [KEY_W-1:0]       roster_key_mem [ROSTER_SLOTS];
    logic [GROUP_W-1:0]     roster_grp_mem [ROSTER_SLOTS];
    int                     roster_len;
    logic [KEY_W-1:0]       line_key_mem [LINE_SLOTS];
    logic [GROUP_W-1:0]     line_grp_mem [LINE_SLOTS];
    int                     line_len;
    logic [GROUP_W-1:0]     grp_limit;

    reply_t                 pending_replies [$];
    int                     fail_count;
    int                     idle_pct;
    int                     stall_pct;

    stim_row_t dir_rows [DIR_COUNT] = '{
        '{OP_DEQUEUE,  32'h0000_0000, 8'd0,   1'b1, '{ST_EMPTY,      32'h0, 8'h0}},
        '{OP_ENQUEUE,  32'h0000_0000, 8'd0,   1'b1, '{ST_UNKNOWN,    32'h0, 8'h0}},
        '{OP_REGISTER, 32'hFFFF_FFFF, 8'd0,   1'b1, '{ST_REJECTED,   32'h0, 8'h0}},
        '{OP_REGISTER, 32'hFFFF_FFFF, 8'd255, 1'b1, '{ST_REGISTERED, 32'h0, 8'h0}},
        '{OP_REGISTER, 32'h0000_0000, 8'd1,   1'b1, '{ST_REGISTERED, 32'h0, 8'h0}},
        '{OP_REGISTER, 32'h0000_00A5, 8'd2,   1'b0, NO_REPLY},
        '{OP_REGISTER, 32'hFFFF_FFFF, 8'd7,   1'b0, NO_REPLY},
        '{OP_NONE,     32'h5A5A_5A5A, 8'hAA,  1'b0, NO_REPLY},
        '{OP_ENQUEUE,  32'hFFFF_FFFF, 8'd0,   1'b0, NO_REPLY},
        '{OP_ENQUEUE,  32'h0000_0000, 8'hFF,  1'b0, NO_REPLY},
        '{OP_ENQUEUE,  32'h0000_00A5, 8'd0,   1'b0, NO_REPLY},
        '{OP_ENQUEUE,  32'hFFFF_FFFF, 8'd0,   1'b0, NO_REPLY},
        '{OP_ENQUEUE,  32'h0000_0000, 8'd0,   1'b0, NO_REPLY},
        '{OP_ENQUEUE,  32'h1234_5678, 8'd0,   1'b1, '{ST_UNKNOWN,    32'h0, 8'h0}},
        '{OP_DEQUEUE,  32'h0000_0000, 8'd0,   1'b0, NO_REPLY},
        '{OP_DEQUEUE,  32'hFFFF_FFFF, 8'hFF,  1'b0, NO_REPLY},
        '{OP_DEQUEUE,  32'h0000_0000, 8'd0,   1'b0, NO_REPLY},
        '{OP_ENQUEUE,  32'h0000_00A5, 8'd0,   1'b0, NO_REPLY},
        '{OP_DEQUEUE,  32'h0000_0000, 8'd0,   1'b0, NO_REPLY},
        '{OP_DEQUEUE,  32'h0000_0000, 8'd0,   1'b0, NO_REPLY},
        '{OP_DEQUEUE,  32'h0000_0000, 8'd0,   1'b0, NO_REPLY},
        '{OP_DEQUEUE,  32'h0000_0000, 8'd0,   1'b1, '{ST_EMPTY,      32'h0, 8'h0}},
        '{OP_REGISTER, 32'h0F0F_0F0F, 8'h80,  1'b0, NO_REPLY}
    };

    group_order_queue uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .operation    (operation),
        .student_key  (student_key),
        .group_number (group_number),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .head_key     (head_key),
        .head_group   (head_group)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    // team queue update for one word; has_reply is low for the unused operation
    task automatic team_queue_step(input op_t op, input logic [KEY_W-1:0] key,
                                   input logic [GROUP_W-1:0] grp,
                                   output bit has_reply, output reply_t r);
        int               i;
        int               pos;
        bit               seen;
        bit               known;
        logic [GROUP_W-1:0] g;
        has_reply = 1'b1;
        r = NO_REPLY;
        case (op)
            OP_REGISTER:
            begin
                if (grp == 0 || grp > grp_limit)
                    r.st = ST_REJECTED;
                else if (roster_len >= ROSTER_SLOTS)
                    r.st = ST_FULL;
                else
                begin
                    roster_key_mem[roster_len] = key;
                    roster_grp_mem[roster_len] = grp;
                    roster_len++;
                    r.st = ST_REGISTERED;
                end
            end
            OP_ENQUEUE:
            begin
                known = 1'b0;
                g = '0;
                for (i = 0; i < roster_len; i++)
                begin
                    if (roster_key_mem[i] == key)
                    begin
                        g = roster_grp_mem[i];
                        known = 1'b1;
                        break;
                    end
                end
                if (!known)
                    r.st = ST_UNKNOWN;
                else if (line_len >= LINE_SLOTS)
                    r.st = ST_FULL;
                else
                begin
                    pos = line_len;
                    seen = 1'b0;
                    for (i = 0; i < line_len; i++)
                    begin
                        if (line_grp_mem[i] == g)
                            seen = 1'b1;
                        else if (seen)
                        begin
                            pos = i;
                            break;
                        end
                    end
                    for (i = line_len; i > pos; i--)
                    begin
                        line_key_mem[i] = line_key_mem[i-1];
                        line_grp_mem[i] = line_grp_mem[i-1];
                    end
                    line_key_mem[pos] = key;
                    line_grp_mem[pos] = g;
                    line_len++;
                    r.st = ST_ENQUEUED;
                end
            end
            OP_DEQUEUE:
            begin
                if (line_len == 0)
                    r.st = ST_EMPTY;
                else
                begin
                    r.st = ST_DEQUEUED;
                    r.key = line_key_mem[0];
                    r.grp = line_grp_mem[0];
                    for (i = 1; i < line_len; i++)
                    begin
                        line_key_mem[i-1] = line_key_mem[i];
                        line_grp_mem[i-1] = line_grp_mem[i];
                    end
                    line_len--;
                end
            end
            default:
                has_reply = 1'b0;
        endcase
    endtask

    task automatic send_word(input op_t op, input logic [KEY_W-1:0] key,
                             input logic [GROUP_W-1:0] grp, input bit typed,
                             input reply_t want);
        bit     has_reply;
        reply_t r;
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid   <= 1'b1;
        operation    <= op;
        student_key  <= key;
        group_number <= grp;
        do
        begin
            @(posedge clk);
        end
        while (item_stall);
        team_queue_step(op, key, grp, has_reply, r);
        if (has_reply)
            pending_replies.push_back(typed ? want : r);
    endtask

    // sender pauses until every reply is back, then idles so a dropped word also clears
    task automatic drain_replies();
        item_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_group_count(input logic [GROUP_W-1:0] value);
        drain_replies();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        grp_limit = value;
    endtask

    function automatic logic [KEY_W-1:0] known_key();
        return roster_key_mem[$urandom_range(roster_len - 1)];
    endfunction

    task automatic random_words(input int count, input bool_mid_pause);
        int                 done;
        int                 pick;
        int                 top;
        op_t                op;
        logic [KEY_W-1:0]   key;
        logic [GROUP_W-1:0] grp;
        done = 0;
        while (done < count)
        begin
            pick = $urandom_range(99);
            top = (grp_limit == 0 || grp_limit > 6) ? 6 : grp_limit;
            if ($urandom_range(99) < 80)
                grp = GROUP_W'($urandom_range(top, 1));
            else
                grp = GROUP_W'($urandom_range(255));
            if (pick < 25)
            begin
                op = OP_REGISTER;
                key = (roster_len > 0 && $urandom_range(99) < 30) ? known_key() : $urandom;
            end
            else if (pick < 65)
            begin
                op = OP_ENQUEUE;
                key = (roster_len > 0 && $urandom_range(99) < 85) ? known_key() : $urandom;
            end
            else if (pick < 95)
            begin
                op = OP_DEQUEUE;
                key = $urandom;
            end
            else
            begin
                op = OP_NONE;
                key = $urandom;
            end
            send_word(op, key, grp, 1'b0, NO_REPLY);
            if (op != OP_NONE)
                done++;
            if (bool_mid_pause && done == count / 2)
                drain_replies();
        end
    endtask

    task automatic run_phase(input logic [GROUP_W-1:0] limit, input int idle,
                             input int stall, input int count);
        write_group_count(limit);
        idle_pct  = idle;
        stall_pct = stall;
        random_words(count, 1'b1);
    endtask

    initial
    begin
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        reply_t want;
        reply_t got;
        if (rst_n && result_valid && !result_stall)
        begin
            got.st  = status_t'(status);
            got.key = head_key;
            got.grp = head_group;
            if (pending_replies.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected word: status %0d key %h group %0d",
                             status, head_key, head_group);
            end
            else
            begin
                want = pending_replies[0];
                pending_replies.delete(0);
                if (got !== want)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: want st %0d key %h grp %0d, got st %0d key %h grp %0d",
                                 want.st, want.key, want.grp, status, head_key, head_group);
                end
            end
        end
    end

    initial
    begin
        int i;
        fail_count   = 0;
        roster_len   = 0;
        line_len     = 0;
        grp_limit    = GROUP_COUNT_RESET;
        idle_pct     = 0;
        stall_pct    = 0;
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_data     <= GROUP_COUNT_RESET;
        item_valid   <= 1'b0;
        operation    <= OP_NONE;
        student_key  <= '0;
        group_number <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_COUNT; i++)
            send_word(dir_rows[i].op, dir_rows[i].key, dir_rows[i].grp,
                      dir_rows[i].typed, dir_rows[i].want);

        run_phase(8'd1, 0, 0, 50);
        run_phase(8'd0, 61, 0, 50);
        run_phase(GROUP_W'($urandom_range(254, 2)), 0, 61, 50);
        run_phase(8'd255, 11, 11, 50);

        // fill the roster, then hit the range check and the full check
        write_group_count(8'd8);
        idle_pct  = 11;
        stall_pct = 11;
        while (roster_len < ROSTER_SLOTS)
            send_word(OP_REGISTER, $urandom, GROUP_W'($urandom_range(8, 1)), 1'b0, NO_REPLY);
        send_word(OP_REGISTER, $urandom, 8'd0, 1'b1, '{ST_REJECTED, 32'h0, 8'h0});
        send_word(OP_REGISTER, $urandom, 8'd8, 1'b1, '{ST_FULL, 32'h0, 8'h0});

        // fill the line, overflow it, then take a few words off the full line
        while (line_len < LINE_SLOTS)
            send_word(OP_ENQUEUE, known_key(), 8'd0, 1'b0, NO_REPLY);
        send_word(OP_ENQUEUE, known_key(), 8'd0, 1'b1, '{ST_FULL, 32'h0, 8'h0});
        send_word(OP_ENQUEUE, $urandom, 8'd0, 1'b0, NO_REPLY);
        repeat (4)
            send_word(OP_DEQUEUE, $urandom, 8'd0, 1'b0, NO_REPLY);

        drain_replies();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending_replies.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: group_order_queue.f
hw/rtl/goq_pkg.sv
hw/rtl/goq_roster_cell.sv
hw/rtl/goq_queue_cell.sv
hw/rtl/goq_roster.sv
hw/rtl/goq_queue.sv
hw/rtl/group_order_queue.sv
bench/tb_top.sv
